FILE: sv/mhpq_pkg.sv
// mhpq_pkg: shared types and constants for the min-heap priority queue.
// No dependencies. Used by mhpq_ctrl, mhpq_dp, the top level and the checker.
package mhpq_pkg;

    localparam int DATA_W = 32;
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [0:0] {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } kind_e;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_e;

    typedef struct packed {
        kind_e                     kind;
        logic signed [DATA_W-1:0]  value;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  top_value;
        logic                      top_valid;
        logic [CNT_W-1:0]          entry_count;
        status_e                   status;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic ld_push;    // capture value, hole at tail, count up
        logic ld_pop;     // count down, read last entry
        logic take_last;  // capture last entry as the moving value
        logic rd_up;      // read parent of hole
        logic rd_down;    // read both children of hole
        logic place;      // write moving value into hole
        logic move_up;    // parent moves into hole, hole goes up
        logic move_down;  // smaller child moves into hole, hole goes down
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
        logic at_root;
        logic up_lt;
        logic has_kid;
        logic down_lt;
    } sts_t;

endpackage

FILE: sv/mhpq_ctrl.sv
// mhpq_ctrl: sequencing state machine for push/sift-up and pop/sift-down.
// Depends on mhpq_pkg (cmd_t, sts_t, kind_e, status_e).
module mhpq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  mhpq_pkg::kind_e in_kind,
    output logic           in_ready,
    input  mhpq_pkg::sts_t sts,
    input  logic           out_free,
    output mhpq_pkg::cmd_t cmd,
    output logic           finish,
    output mhpq_pkg::status_e status
);
    import mhpq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_POP_LOAD,
        S_DN_CHK,
        S_DN_CMP,
        S_FIN
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    status_e status_reg;
    status_e status_next;

    assign in_ready = (state_reg == S_IDLE);
    assign status   = status_reg;

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        finish      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    status_next = ST_OK;
                    if (in_kind == KIND_PUSH)
                    begin
                        if (sts.full)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            cmd.ld_push = 1'b1;
                            state_next  = S_UP_CHK;
                        end
                    end
                    else
                    begin
                        if (sts.empty)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            cmd.ld_pop = 1'b1;
                            state_next = S_POP_LOAD;
                        end
                    end
                end
            end
            S_UP_CHK:
            begin
                if (sts.at_root)
                begin
                    cmd.place  = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.rd_up  = 1'b1;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (sts.up_lt)
                begin
                    cmd.move_up = 1'b1;
                    state_next  = S_UP_CHK;
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_POP_LOAD:
            begin
                cmd.take_last = 1'b1;
                state_next    = S_DN_CHK;
            end
            S_DN_CHK:
            begin
                if (sts.has_kid)
                begin
                    cmd.rd_down = 1'b1;
                    state_next  = S_DN_CMP;
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_DN_CMP:
            begin
                if (sts.down_lt)
                begin
                    cmd.move_down = 1'b1;
                    state_next    = S_DN_CHK;
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule

FILE: sv/mhpq_dp.sv
// mhpq_dp: heap memory, hole position, moving value, entry count and compares.
// Depends on mhpq_pkg (cmd_t, sts_t, constants).
module mhpq_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mhpq_pkg::cmd_t                     cmd,
    input  logic signed [mhpq_pkg::DATA_W-1:0] in_value,
    output mhpq_pkg::sts_t                     sts,
    output logic signed [mhpq_pkg::DATA_W-1:0] top_value,
    output logic [mhpq_pkg::CNT_W-1:0]         count
);
    import mhpq_pkg::*;

    logic signed [DATA_W-1:0] heap_mem [DEPTH];

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [ADDR_W-1:0]        pos_reg;
    logic [ADDR_W-1:0]        pos_next;
    logic signed [DATA_W-1:0] cur_reg;
    logic signed [DATA_W-1:0] top_reg;
    logic signed [DATA_W-1:0] rd_a_reg;
    logic signed [DATA_W-1:0] rd_b_reg;

    logic [ADDR_W-1:0]        pos_m1;
    logic [ADDR_W-1:0]        parent;
    logic [CNT_W:0]           kid_l;
    logic [CNT_W:0]           kid_r;
    logic [CNT_W-1:0]         cnt_m1;
    logic                     right_ok;
    logic                     pick_right;
    logic signed [DATA_W-1:0] child_val;
    logic [ADDR_W-1:0]        child_addr;
    logic [ADDR_W-1:0]        rd_addr_a;
    logic [ADDR_W-1:0]        rd_addr_b;
    logic                     wr_en;
    logic signed [DATA_W-1:0] wr_data;

    // heap index arithmetic: parent = (pos-1)/2, children = 2*pos+1, 2*pos+2
    assign pos_m1   = pos_reg - ADDR_W'(1);
    assign parent   = {1'b0, pos_m1[ADDR_W-1:1]};
    assign kid_l    = (CNT_W + 1)'({pos_reg, 1'b1});
    assign kid_r    = kid_l + (CNT_W + 1)'(1);
    assign cnt_m1   = count_reg - CNT_W'(1);
    assign right_ok = (kid_r < {1'b0, count_reg});

    // left child wins ties
    assign pick_right = right_ok && (rd_b_reg < rd_a_reg);
    assign child_val  = pick_right ? rd_b_reg : rd_a_reg;
    assign child_addr = pick_right ? kid_r[ADDR_W-1:0] : kid_l[ADDR_W-1:0];

    assign sts.full    = (count_reg == CNT_W'(DEPTH));
    assign sts.empty   = (count_reg == '0);
    assign sts.at_root = (pos_reg == '0);
    assign sts.up_lt   = (cur_reg < rd_a_reg);
    assign sts.has_kid = (kid_l < {1'b0, count_reg});
    assign sts.down_lt = (child_val < cur_reg);

    always_comb
    begin
        priority if (cmd.rd_down)
            rd_addr_a = kid_l[ADDR_W-1:0];
        else if (cmd.ld_pop)
            rd_addr_a = cnt_m1[ADDR_W-1:0];
        else
            rd_addr_a = parent;
    end
    assign rd_addr_b = kid_r[ADDR_W-1:0];

    assign wr_en = cmd.place | cmd.move_up | cmd.move_down;

    always_comb
    begin
        priority if (cmd.move_up)
            wr_data = rd_a_reg;
        else if (cmd.move_down)
            wr_data = child_val;
        else
            wr_data = cur_reg;
    end

    always_comb
    begin
        pos_next = pos_reg;
        priority if (cmd.ld_push)
            pos_next = count_reg[ADDR_W-1:0];
        else if (cmd.ld_pop)
            pos_next = '0;
        else if (cmd.move_up)
            pos_next = parent;
        else if (cmd.move_down)
            pos_next = child_addr;
    end

    always_comb
    begin
        count_next = count_reg;
        priority if (cmd.ld_push)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.ld_pop)
            count_next = cnt_m1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        if (cmd.ld_push)
            cur_reg <= in_value;
        else if (cmd.take_last)
            cur_reg <= rd_a_reg;
        // shadow copy of slot 0 so the minimum needs no extra read
        if (wr_en && (pos_reg == '0))
            top_reg <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            heap_mem[pos_reg] <= wr_data;
        rd_a_reg <= heap_mem[rd_addr_a];
        rd_b_reg <= heap_mem[rd_addr_b];
    end

    assign top_value = top_reg;
    assign count     = count_reg;

endmodule

FILE: sv/min_heap_priority_queue.sv
// min_heap_priority_queue: top level, binary min-heap with 64 signed 32-bit entries.
// Depends on mhpq_pkg, mhpq_ctrl and mhpq_dp.
//
//   channel | signals                       | payload type       | direction
//   --------+-------------------------------+--------------------+----------
//   input   | in_valid, in_ready, in_item   | mhpq_pkg::item_t   | in
//   output  | out_valid, out_ready, out_item| mhpq_pkg::result_t | out
//
// One item is worked at a time; in_ready is high only while the sequencer idles.
// A push climbs while the moving value is below its parent; a pop descends while the
// smaller child is below the moving value. Each heap level takes a read state and a
// compare state because the heap memory read is registered. A dropped push or an
// empty pop goes straight to the final state.
// Reset is asynchronous, active low: the heap comes up empty, memory is not cleared.
// A result sits in the output register while the next transaction is accepted; the
// sequencer holds in its final state, in_ready low, until that result is taken.
module min_heap_priority_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mhpq_pkg::item_t   in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output mhpq_pkg::result_t out_item
);
    import mhpq_pkg::*;

    cmd_t                     cmd;
    sts_t                     sts;
    logic                     finish;
    status_e                  status;
    logic                     out_free;
    logic signed [DATA_W-1:0] heap_top;
    logic [CNT_W-1:0]         heap_count;

    logic                     out_valid_reg;
    result_t                  out_item_reg;
    result_t                  result;

    // the output slot frees up in the same cycle the consumer takes it
    assign out_free = !out_valid_reg || out_ready;

    mhpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_kind  (in_item.kind),
        .in_ready (in_ready),
        .sts      (sts),
        .out_free (out_free),
        .cmd      (cmd),
        .finish   (finish),
        .status   (status)
    );

    mhpq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_value  (in_item.value),
        .sts       (sts),
        .top_value (heap_top),
        .count     (heap_count)
    );

    // heap state as it stands once the sift is done; empty heap shows zero
    always_comb
    begin
        result.top_valid   = (heap_count != '0);
        result.top_value   = result.top_valid ? heap_top : '0;
        result.entry_count = heap_count;
        result.status      = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
            out_item_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: sv/mhpq_checker.sv
// mhpq_checker: port-level assertions for min_heap_priority_queue, plus bind.
// Depends on mhpq_pkg and the top level's port list.
module mhpq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input mhpq_pkg::result_t out_item
);
    import mhpq_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // one transaction at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted while previous transaction in flight");

    // top_valid tracks the count, empty heap shows zero
    a_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.top_valid == (out_item.entry_count != '0))
                      && (out_item.top_valid || (out_item.top_value == '0)))
        else $error("top fields disagree with entry count");

    // count never exceeds capacity
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.entry_count <= CNT_W'(DEPTH))
        else $error("entry count out of range");

    // error codes only where the count allows them
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.status != ST_FULL || out_item.entry_count == CNT_W'(DEPTH))
                      && (out_item.status != ST_EMPTY || out_item.entry_count == '0))
        else $error("status inconsistent with entry count");

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

FILE: tb/testbench.sv
// testbench: self-checking bench for min_heap_priority_queue, random and directed push/pop.
// Depends on mhpq_pkg and min_heap_priority_queue; a heap tracker class predicts each result.

class heap_tracker;
    localparam int SLOTS = mhpq_pkg::DEPTH;

    logic signed [mhpq_pkg::DATA_W-1:0] slots [SLOTS];
    int                                 fill;
    mhpq_pkg::result_t                  pending [$];
    int                                 errors;

    function new();
        fill   = 0;
        errors = 0;
    endfunction

    task report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    function void swap_slots(int a, int b);
        logic signed [mhpq_pkg::DATA_W-1:0] t;
        t        = slots[a];
        slots[a] = slots[b];
        slots[b] = t;
    endfunction

    // Updates the tracked heap for one accepted transaction and queues its result.
    function void note_op(mhpq_pkg::item_t it);
        mhpq_pkg::result_t r;
        int                pos;
        int                kid;
        r.status = mhpq_pkg::ST_OK;
        if (it.kind == mhpq_pkg::KIND_PUSH) begin
            if (fill >= SLOTS) begin
                r.status = mhpq_pkg::ST_FULL;
            end
            else begin
                slots[fill] = it.value;
                pos = fill;
                fill++;
                // climb while strictly smaller than the parent
                while (pos > 0 && slots[pos] < slots[(pos - 1) / 2]) begin
                    swap_slots(pos, (pos - 1) / 2);
                    pos = (pos - 1) / 2;
                end
            end
        end
        else begin
            if (fill == 0) begin
                r.status = mhpq_pkg::ST_EMPTY;
            end
            else begin
                fill--;
                slots[0] = slots[fill];
                pos = 0;
                // descend; left child wins ties, parent stays on a tie
                forever begin
                    kid = 2 * pos + 1;
                    if (kid >= fill)
                        break;
                    if (kid + 1 < fill && slots[kid + 1] < slots[kid])
                        kid++;
                    if (!(slots[kid] < slots[pos]))
                        break;
                    swap_slots(kid, pos);
                    pos = kid;
                end
            end
        end
        r.top_value   = (fill > 0) ? slots[0] : '0;
        r.top_valid   = (fill > 0);
        r.entry_count = mhpq_pkg::CNT_W'(fill);
        pending.push_back(r);
    endfunction

    task check_result(mhpq_pkg::result_t got);
        mhpq_pkg::result_t want;
        if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", got));
        end
        else begin
            want = pending.pop_front();
            if (got.top_value !== want.top_value)
                report_mismatch($sformatf("top_value %0d, expected %0d",
                                          got.top_value, want.top_value));
            if (got.top_valid !== want.top_valid)
                report_mismatch($sformatf("top_valid %b, expected %b",
                                          got.top_valid, want.top_valid));
            if (got.entry_count !== want.entry_count)
                report_mismatch($sformatf("entry_count %0d, expected %0d",
                                          got.entry_count, want.entry_count));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d",
                                          got.status, want.status));
        end
    endtask
endclass

module testbench;
    import mhpq_pkg::*;

    localparam int STALL_LIMIT  = 5000;   // cycles without any transaction
    localparam int PHASE_ITEMS  = 175;
    localparam int DRAIN_CYCLES = 40;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    in_valid  = 1'b0;
    logic    in_ready;
    item_t   in_item   = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    result_t out_item;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles = 0;
    heap_tracker tracker;

    min_heap_priority_queue DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always #5 clk = ~clk;

    // Receiver: random backpressure, check every accepted result.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            tracker.check_result(out_item);
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Count cycles with no transaction on either channel.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic item_t make_item(kind_e k, logic signed [DATA_W-1:0] v);
        item_t it;
        it.kind  = k;
        it.value = v;
        return it;
    endfunction

    // Mix of full-range, tie-prone small, moderate and extreme values.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50)
            return $urandom;
        else if (sel < 75)
            return $signed($urandom_range(8)) - 4;
        else if (sel < 85)
            case ($urandom_range(3))
                0: return 32'sh7fffffff;
                1: return 32'sh80000000;
                2: return 0;
                default: return -1;
            endcase
        else
            return $signed($urandom_range(2000)) - 1000;
    endfunction

    // Holds the transaction on the bus until accepted; random idle cycles before it.
    task automatic send_item(item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.note_op(it);
    endtask

    task automatic run_directed();
        send_item(make_item(KIND_POP, 32'sh12345678));   // pop on empty
        send_item(make_item(KIND_PUSH, 0));
        send_item(make_item(KIND_PUSH, 32'sh7fffffff));
        send_item(make_item(KIND_PUSH, 32'sh80000000));
        send_item(make_item(KIND_PUSH, -1));
        send_item(make_item(KIND_PUSH, -1));              // equal to parent
        send_item(make_item(KIND_PUSH, 32'sh80000000));   // equal to root
        send_item(make_item(KIND_PUSH, 5));
        send_item(make_item(KIND_PUSH, 3));
        send_item(make_item(KIND_PUSH, 1));
        send_item(make_item(KIND_PUSH, 1));
        repeat (10)
            send_item(make_item(KIND_POP, $urandom));     // value ignored
        send_item(make_item(KIND_POP, 32'shffffffff));    // empty again
    endtask

    // Push- and pop-biased bursts, some balanced, fill the heap and drain past empty.
    task automatic run_random(int count);
        int sent;
        int burst;
        int push_pct;
        int mode;
        sent = 0;
        mode = 0;
        while (sent < count) begin
            burst = $urandom_range(100, 70);
            if ($urandom_range(9) == 0)
                push_pct = 50;
            else
                push_pct = (mode == 0) ? 90 : 10;
            mode = 1 - mode;
            repeat (burst) begin
                if (sent < count) begin
                    if ($urandom_range(99) < push_pct)
                        send_item(make_item(KIND_PUSH, pick_value()));
                    else
                        send_item(make_item(KIND_POP, $urandom));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        tracker = new();
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        send_idle_pct = 0;  recv_stall_pct = 0;
        run_random(PHASE_ITEMS);
        send_idle_pct = 53; recv_stall_pct = 0;
        run_random(PHASE_ITEMS);
        send_idle_pct = 0;  recv_stall_pct = 53;
        run_random(PHASE_ITEMS);
        send_idle_pct = 32; recv_stall_pct = 32;
        run_random(PHASE_ITEMS);

        in_valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
